// ===== hw/rtl/kse_pkg.sv =====
// Package for the keypad scanner with line entry: shared types, constants and the
// fixed key table. It has no dependencies; every module of the block imports it.
package kse_pkg;

   localparam int ROWS                = 4;
   localparam int COLS                = 4;
   localparam int ROW_W               = $clog2(ROWS);
   localparam int ENTRY_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [7:0]  FILL_BYTE      = 8'hFF;

   typedef enum logic [1:0] {
      PH_RELEASE,
      PH_PRESS,
      PH_DEBOUNCE,
      PH_SCAN
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_CHAR  = 3'd1,
      ACT_BACK  = 3'd2,
      ACT_CLEAR = 3'd3,
      ACT_ENTER = 3'd4
   } action_type;

   // One classified request, passed from the scanner to the entry logic.
   typedef struct packed {
      logic [3:0] row_drive;
      logic       key_event;
      action_type key_action;
      logic [7:0] key_char;
      logic       take_entry;
      logic [3:0] read_index;
   } key_item_type;

   function automatic action_type key_action_of(input logic [1:0] row, input logic [1:0] col);
      action_type act;
      act = ACT_CHAR;
      if (col == 2'd3) begin
         unique case (row)
            2'd0: act = ACT_BACK;
            2'd1: act = ACT_CLEAR;
            2'd2: act = ACT_CHAR;
            2'd3: act = ACT_ENTER;
         endcase
      end
      return act;
   endfunction

   function automatic logic [7:0] key_char_of(input logic [1:0] row, input logic [1:0] col);
      logic [7:0] ch;
      ch = 8'h00;
      unique case ({row, col})
         4'h0: ch = "1";
         4'h1: ch = "2";
         4'h2: ch = "3";
         4'h3: ch = 8'h00;
         4'h4: ch = "4";
         4'h5: ch = "5";
         4'h6: ch = "6";
         4'h7: ch = 8'h00;
         4'h8: ch = "7";
         4'h9: ch = "8";
         4'hA: ch = "9";
         4'hB: ch = "C";
         4'hC: ch = "*";
         4'hD: ch = "0";
         4'hE: ch = "#";
         4'hF: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/kse_front.sv =====
// Scanner front end: release/press/debounce/row-scan sequencer and key decode.
// Depends on kse_pkg; feeds classified requests into kse_queue.
module kse_front
   import kse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [3:0]   req_col_sense,
   input  logic         req_take_entry,
   input  logic [3:0]   req_read_index,
   input  logic         csr_valid,
   input  logic [15:0]  csr_debounce_ticks,
   input  logic         q_full,
   output logic         push,
   output key_item_type push_item
);

   phase_type          phase_ff, phase_in;
   logic [15:0]        count_ff, count_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic               found;
   logic [1:0]         col;
   logic [15:0]        count_inc;

   assign push = req_valid && !q_full;

   always_comb begin
      found = 1'b0;
      col   = 2'd0;
      for (int c = 0; c < COLS; c++) begin
         if (!req_col_sense[c]) begin
            found = 1'b1;
            col   = 2'(c);
         end
      end
   end

   assign ticks_in  = csr_valid ? csr_debounce_ticks : ticks_ff;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;

   always_comb begin
      phase_in             = phase_ff;
      count_in             = count_ff;
      row_in               = row_ff;
      push_item.key_event  = 1'b0;
      push_item.key_action = ACT_NONE;
      push_item.key_char   = 8'h00;
      if (push) begin
         unique case (phase_ff)
            PH_RELEASE: begin
               if (!found) phase_in = PH_PRESS;
            end
            PH_PRESS: begin
               if (found) begin
                  count_in = 16'd0;
                  if (ticks_ff == 16'd0) begin
                     phase_in = PH_SCAN;
                     row_in   = '0;
                  end else begin
                     phase_in = PH_DEBOUNCE;
                  end
               end
            end
            PH_DEBOUNCE: begin
               count_in = count_inc;
               if (count_inc >= ticks_ff) begin
                  if (found) begin
                     phase_in = PH_SCAN;
                     row_in   = '0;
                  end else begin
                     phase_in = PH_PRESS;
                  end
               end
            end
            PH_SCAN: begin
               if (found) begin
                  push_item.key_event  = 1'b1;
                  push_item.key_action = key_action_of(2'(row_ff), col);
                  push_item.key_char   = key_char_of(2'(row_ff), col);
                  phase_in             = PH_RELEASE;
               end else if (row_ff == ROW_W'(ROWS - 1)) begin
                  row_in = '0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            default: phase_in = PH_RELEASE;
         endcase
      end
      // The row pattern reflects the phase that the next tick will see.
      push_item.row_drive  = (phase_in == PH_SCAN) ? ~(4'b0001 << row_in) : 4'b0000;
      push_item.take_entry = req_take_entry;
      push_item.read_index = req_read_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASE;
         count_ff <= 16'd0;
         row_ff   <= '0;
         ticks_ff <= DEBOUNCE_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         row_ff   <= row_in;
         ticks_ff <= ticks_in;
      end
   end

`ifndef SYNTHESIS
   a_zero_debounce: assert property (@(posedge clock) disable iff (reset)
      push && phase_ff == PH_PRESS && found && ticks_ff == 16'd0 && !csr_valid
      |=> phase_ff == PH_SCAN && row_ff == '0)
      else $error("zero debounce did not start the scan at once");
`endif

endmodule

// ===== hw/rtl/kse_queue.sv =====
// Short request queue between the scanner front end and the entry back end.
// Depends on kse_pkg for the item type and depth.
module kse_queue
   import kse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  key_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         q_valid,
   output key_item_type q_item
);

   key_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("request queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue count out of range");
`endif

endmodule

// ===== hw/rtl/kse_back.sv =====
// Entry back end: applies decoded keys to the entry buffer and holds the result
// register. Depends on kse_pkg; takes requests from kse_queue.
module kse_back
   import kse_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEFAULT,
   localparam int LEN_W      = $clog2(ENTRY_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  key_item_type     q_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_row_drive,
   output logic             rsp_key_event,
   output logic [2:0]       rsp_key_action,
   output logic [7:0]       rsp_key_char,
   output logic [LEN_W-1:0] rsp_entry_length,
   output logic             rsp_entry_done,
   output logic [7:0]       rsp_read_char
);

   logic [7:0]       buf_ff [ENTRY_DEPTH];
   logic [7:0]       buf_in [ENTRY_DEPTH];
   logic [7:0]       buf_new [ENTRY_DEPTH];
   logic [LEN_W-1:0] pos_ff, pos_in, pos_new;
   logic             done_ff, done_in, done_new;
   logic [7:0]       rd_byte;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       row_drive_ff, row_drive_in;
   logic             key_event_ff, key_event_in;
   action_type       key_action_ff, key_action_in;
   logic [7:0]       key_char_ff, key_char_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             entry_done_ff, entry_done_in;
   logic [7:0]       read_char_ff, read_char_in;

   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // Effect of the key on the buffer; read_char sees the buffer after the key.
   always_comb begin
      buf_new  = buf_ff;
      pos_new  = pos_ff;
      done_new = done_ff;
      if (q_item.key_action == ACT_CLEAR) begin
         for (int i = 0; i < ENTRY_DEPTH; i++) buf_new[i] = 8'h00;
         pos_new  = '0;
         done_new = 1'b0;
      end else if (!done_ff) begin
         unique case (q_item.key_action)
            ACT_CHAR: begin
               if (pos_ff < LEN_W'(ENTRY_DEPTH)) begin
                  for (int i = 0; i < ENTRY_DEPTH; i++) begin
                     if (pos_ff == LEN_W'(i)) buf_new[i] = q_item.key_char;
                  end
                  pos_new = pos_ff + LEN_W'(1);
               end
            end
            ACT_BACK: begin
               if (pos_ff != '0) begin
                  pos_new = pos_ff - LEN_W'(1);
                  for (int i = 0; i < ENTRY_DEPTH; i++) begin
                     if (pos_new == LEN_W'(i)) buf_new[i] = 8'h00;
                  end
               end
            end
            ACT_ENTER: begin
               if (pos_ff < LEN_W'(ENTRY_DEPTH)) begin
                  for (int i = 0; i < ENTRY_DEPTH; i++) begin
                     if (pos_ff == LEN_W'(i)) begin
                        buf_new[i] = 8'h00;
                     end else if (pos_ff < LEN_W'(i)) begin
                        buf_new[i] = FILL_BYTE;
                     end
                  end
               end
               done_new = 1'b1;
            end
            default: ;
         endcase
      end
      rd_byte = 8'h00;
      for (int i = 0; i < ENTRY_DEPTH; i++) begin
         if (int'(q_item.read_index) == i) rd_byte = buf_new[i];
      end
   end

   always_comb begin
      buf_in        = buf_ff;
      pos_in        = pos_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff;
      row_drive_in  = row_drive_ff;
      key_event_in  = key_event_ff;
      key_action_in = key_action_ff;
      key_char_in   = key_char_ff;
      length_in     = length_ff;
      entry_done_in = entry_done_ff;
      read_char_in  = read_char_ff;
      if (pop) begin
         if (q_item.take_entry) begin
            for (int i = 0; i < ENTRY_DEPTH; i++) buf_in[i] = 8'h00;
            pos_in  = '0;
            done_in = 1'b0;
         end else begin
            buf_in  = buf_new;
            pos_in  = pos_new;
            done_in = done_new;
         end
         rsp_valid_in  = 1'b1;
         row_drive_in  = q_item.row_drive;
         key_event_in  = q_item.key_event;
         key_action_in = q_item.key_action;
         key_char_in   = q_item.key_char;
         length_in     = pos_new;
         entry_done_in = done_new;
         read_char_in  = rd_byte;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_DEPTH; i++) buf_ff[i] <= 8'h00;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_drive_ff  <= row_drive_in;
      key_event_ff  <= key_event_in;
      key_action_ff <= key_action_in;
      key_char_ff   <= key_char_in;
      length_ff     <= length_in;
      entry_done_ff <= entry_done_in;
      read_char_ff  <= read_char_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_drive    = row_drive_ff;
   assign rsp_key_event    = key_event_ff;
   assign rsp_key_action   = key_action_ff;
   assign rsp_key_char     = key_char_ff;
   assign rsp_entry_length = length_ff;
   assign rsp_entry_done   = entry_done_ff;
   assign rsp_read_char    = read_char_ff;

`ifndef SYNTHESIS
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LEN_W'(ENTRY_DEPTH))
      else $error("entry length beyond buffer depth");
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      pop && q_item.take_entry |=> pos_ff == '0 && !done_ff)
      else $error("taking the entry did not clear it");
`endif

endmodule

// ===== hw/rtl/keypad_scan_line_entry_top.sv =====
// Top level of the keypad scanner with line entry.
// Depends on kse_pkg and instantiates kse_front, kse_queue and kse_back.
//
// Usage: every request on the req_ channel is one scan tick carrying the sensed
// active-low column levels, a take_entry strobe and a buffer read index. Each
// request yields exactly one response on the rsp_ channel: the row levels for
// the next tick, the decoded key (if any), the entry length, the done flag and
// the buffer byte at the read index. Both channels use valid/stall.
// The debounce length is written through csr_valid/csr_ready/csr_debounce_ticks;
// csr_ready is always high and the write should be made while the block is idle.
// An accepted request is written into the queue; in order, it moves into the result
// register once that register is empty or not stalled, and its response is valid there.
// Throughput: one request per cycle; the scanner takes a new request while the
// result register still waits, until the two-entry queue is full.
// Reset (synchronous, active high) returns to waiting for release, restores a
// debounce length of 20 ticks and empties the entry buffer.
// A stalled response holds; the queue then fills and req_stall rises.
module keypad_scan_line_entry_top
   import kse_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [3:0]                         req_col_sense,
   input  logic                               req_take_entry,
   input  logic [3:0]                         req_read_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_row_drive,
   output logic                               rsp_key_event,
   output logic [2:0]                         rsp_key_action,
   output logic [7:0]                         rsp_key_char,
   output logic [$clog2(ENTRY_DEPTH + 1)-1:0] rsp_entry_length,
   output logic                               rsp_entry_done,
   output logic [7:0]                         rsp_read_char,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [15:0]                        csr_debounce_ticks
);

   logic         push;
   logic         pop;
   logic         q_full;
   logic         q_valid;
   key_item_type push_item;
   key_item_type q_item;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   kse_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_col_sense      (req_col_sense),
      .req_take_entry     (req_take_entry),
      .req_read_index     (req_read_index),
      .csr_valid          (csr_valid),
      .csr_debounce_ticks (csr_debounce_ticks),
      .q_full             (q_full),
      .push               (push),
      .push_item          (push_item)
   );

   kse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   kse_back #(
      .ENTRY_DEPTH (ENTRY_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_drive    (rsp_row_drive),
      .rsp_key_event    (rsp_key_event),
      .rsp_key_action   (rsp_key_action),
      .rsp_key_char     (rsp_key_char),
      .rsp_entry_length (rsp_entry_length),
      .rsp_entry_done   (rsp_entry_done),
      .rsp_read_char    (rsp_read_char)
   );

endmodule
